FILE: src/wbpm_pkg.sv
// Package for the wildcard byte pattern matcher.
// Field widths, register indexes and default sizes; no dependencies.
package wbpm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int ADDR_W          = 48;
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int WORD_COUNT      = 4;
	localparam int PAT_W           = WORD_COUNT * CFG_DATA_W;
	localparam int MASK_W          = 32;
	localparam int LEN_W           = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO,
		REG_PAT_MID_LO,
		REG_PAT_MID_HI,
		REG_PAT_HI,
		REG_WILDCARD,
		REG_LENGTH
	} cfg_reg_t;

endpackage

FILE: src/wildcard_byte_pattern_matcher.sv
// Wildcard byte pattern matcher, top level.
// Uses wbpm_pkg for widths and register indexes.
//
// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_stall   | data_byte, byte_address, block_start
// out     | source    | out_valid/out_stall | match_address
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; a result is offered after its byte passes
// the input register, then the window compare into the output register.
// The compare across all pattern positions is combinational logic.
// arst_n clears valids, byte count and configuration registers to their defaults.
// in_stall rises only while a matching byte waits behind a stalled result.
module wildcard_byte_pattern_matcher #(
	parameter int MAX_PATTERN = wbpm_pkg::MAX_PATTERN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [wbpm_pkg::BYTE_W-1:0]         data_byte,
	input  logic [wbpm_pkg::ADDR_W-1:0]         byte_address,
	input  logic                                block_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wbpm_pkg::ADDR_W-1:0]         match_address,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wbpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int WD = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam logic [wbpm_pkg::LEN_W-1:0] MAX_LEN = wbpm_pkg::LEN_W'(MAX_PATTERN);

	logic [wbpm_pkg::PAT_W-1:0]  pat_q;
	logic [wbpm_pkg::MASK_W-1:0] wild_q;
	logic [wbpm_pkg::LEN_W-1:0]  plen_q;

	logic                          vld_s1;
	logic [wbpm_pkg::BYTE_W-1:0]   byte_s1;
	logic [wbpm_pkg::ADDR_W-1:0]   addr_s1;
	logic                          start_s1;

	logic [wbpm_pkg::BYTE_W-1:0]   win_q [WD];
	logic [wbpm_pkg::LEN_W-1:0]    seen_q;

	logic                          out_vld_q;
	logic [wbpm_pkg::ADDR_W-1:0]   out_addr_q;

	logic [wbpm_pkg::BYTE_W-1:0]   seq [MAX_PATTERN];
	logic [wbpm_pkg::LEN_W-1:0]    len_eff;
	logic [wbpm_pkg::LEN_W-1:0]    seen_base;
	logic [wbpm_pkg::LEN_W-1:0]    seen_new;
	logic [MAX_PATTERN-1:0]        pos_ok;
	logic                          hit;
	logic                          adv_s1;
	logic                          load_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			wild_q <= '0;
			plen_q <= wbpm_pkg::LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wbpm_pkg::REG_PAT_LO:     pat_q[0*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W] <= cfg_data;
				wbpm_pkg::REG_PAT_MID_LO: pat_q[1*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W] <= cfg_data;
				wbpm_pkg::REG_PAT_MID_HI: pat_q[2*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W] <= cfg_data;
				wbpm_pkg::REG_PAT_HI:     pat_q[3*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W] <= cfg_data;
				wbpm_pkg::REG_WILDCARD:   wild_q <= cfg_data[wbpm_pkg::MASK_W-1:0];
				wbpm_pkg::REG_LENGTH:     plen_q <= cfg_data[wbpm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// newest byte first: seq[0] is the byte in stage 1
	always_comb begin
		seq[0] = byte_s1;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			seq[j] = win_q[j-1];
		end
	end

	always_comb begin
		logic [wbpm_pkg::LEN_W-1:0] back;
		len_eff   = (plen_q > MAX_LEN) ? MAX_LEN : plen_q;
		seen_base = start_s1 ? '0 : seen_q;
		seen_new  = (seen_base < MAX_LEN) ? seen_base + wbpm_pkg::LEN_W'(1) : seen_base;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			back = len_eff - wbpm_pkg::LEN_W'(1) - wbpm_pkg::LEN_W'(k);
			if (wbpm_pkg::LEN_W'(k) >= len_eff || wild_q[k]) begin
				pos_ok[k] = 1'b1;
			end else begin
				pos_ok[k] = (pat_q[k*wbpm_pkg::BYTE_W +: wbpm_pkg::BYTE_W] == seq[back[IW-1:0]]);
			end
		end
		hit = (len_eff != '0) && (seen_new >= len_eff) && (&pos_ok);
	end

	assign adv_s1   = vld_s1 && (!out_vld_q || !out_stall || !hit);
	assign in_stall = vld_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load_s1) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= data_byte;
			addr_s1  <= byte_address;
			start_s1 <= block_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (adv_s1) begin
			seen_q <= seen_new;
		end
	end

	generate
		if (MAX_PATTERN > 1) begin : g_win
			always_ff @(posedge clk) begin
				if (adv_s1) begin
					win_q[0] <= byte_s1;
					for (int j = 1; j < WD; j++) begin
						win_q[j] <= win_q[j-1];
					end
				end
			end
		end else begin : g_nowin
			always_ff @(posedge clk) begin
				win_q[0] <= '0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && hit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && hit) begin
			out_addr_q <= addr_s1 - wbpm_pkg::ADDR_W'(len_eff) + wbpm_pkg::ADDR_W'(1);
		end
	end

	assign out_valid     = out_vld_q;
	assign match_address = out_addr_q;

endmodule

FILE: src/wbpm_checker.sv
// Port-level checker for the wildcard byte pattern matcher, with its bind.
// Uses wbpm_pkg for port widths.
module wbpm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [wbpm_pkg::ADDR_W-1:0]     match_address,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_address))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted transaction");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind wildcard_byte_pattern_matcher wbpm_checker u_wbpm_checker (.*);
